### rtl/core/submission_completion_ring_control_assert.svh
// Assertion macros shared by the ring control RTL.
`ifndef SUBMISSION_COMPLETION_RING_CONTROL_ASSERT_SVH
`define SUBMISSION_COMPLETION_RING_CONTROL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/scrc_pkg.sv
// Types, codes and constants of the submission/completion ring control.
package scrc_pkg;

    localparam int PTR_W    = 32;
    localparam int ADDR_W   = 64;
    localparam int SIZE_W   = 13;
    localparam int BYTES_W  = 9;
    localparam int LIMIT_W  = 17;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam int SQ_ENTRY_BYTES_DEF   = 48;
    localparam int CQ_ENTRY_BYTES_DEF   = 40;
    localparam int MAX_RING_ENTRIES_DEF = 4096;

    localparam logic [KIND_W-1:0] KIND_SET_SQ_HEAD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET_SQ_TAIL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET_CQ_HEAD = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_CQ_TAIL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NEXT_SQ     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ADV_SQ_HEAD = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NEXT_CQ     = 3'd6;
    localparam logic [KIND_W-1:0] KIND_ADV_CQ_TAIL = 3'd7;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SQ_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CQ_FAIL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SQ_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CQ_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQ_ENTRIES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CQ_ENTRIES = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PTR_W-1:0]  value;
    } scrc_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   record_addr;
        logic [SIZE_W-1:0]   sq_pending;
        logic [SIZE_W-1:0]   cq_filled;
        logic                cq_room;
        logic                sq_ready;
        logic                cq_ready;
        logic [PTR_W-1:0]    sq_head_now;
        logic [PTR_W-1:0]    sq_tail_now;
        logic [PTR_W-1:0]    cq_head_now;
        logic [PTR_W-1:0]    cq_tail_now;
    } scrc_rsp_t;

    typedef struct packed {
        logic              start;
        logic [PTR_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } scrc_div_req_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] remainder;
    } scrc_div_rsp_t;

endpackage

### rtl/core/scrc_divider.sv
// Bit-serial restoring remainder unit: 32-bit pointer modulo ring size.
`include "submission_completion_ring_control_assert.svh"

module scrc_divider
    import scrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  scrc_div_req_t req,
    output scrc_div_rsp_t rsp
);

    localparam int DIV_STEPS = PTR_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W-1:0]  dvd_reg, dvd_next;
    logic [SIZE_W-1:0] dvs_reg, dvs_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   trial_sub;
    logic              fits;

    // one quotient bit per cycle, MSB of the dividend first
    assign trial     = {rem_reg, dvd_reg[PTR_W-1]};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[SIZE_W-1:0] : trial[SIZE_W-1:0];
            dvd_next = {dvd_reg[PTR_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

    `SCRC_ASSERT_NOW(a_rem_below_divisor, done_reg, rem_reg < dvs_reg, "remainder not below divisor")
    `SCRC_ASSERT_NOW(a_done_after_busy, done_reg, !busy_reg, "divider done while still stepping")
    `SCRC_ASSERT_NOW(a_start_when_idle, req.start, !busy_reg && req.divisor != '0, "bad divider start")

endmodule

### rtl/core/submission_completion_ring_control.sv
// Submission/completion ring pointer and record address control, top level.
// Each item is taken when start is high and busy low. Its one result is shown
// for a single cycle with done high. The receiver cannot stall, so it must
// take the result in that cycle. For pointer writes, advances and refused
// address requests, the item goes from apply through depth and check to
// done; a granted address request goes on from check through divide and
// add to done. Busy falls after done, and only then is the next item taken.
// In divide the 32-step bit-serial remainder unit reduces the pointer
// modulo the ring size and the result is multiplied by the record size;
// add then adds it to the base in 64 bits. Configuration writes are taken
// only while busy is low; writing a ring size clears that ring's pointers.
`include "submission_completion_ring_control_assert.svh"

module submission_completion_ring_control
    import scrc_pkg::*;
#(
    parameter int SQ_ENTRY_BYTES   = SQ_ENTRY_BYTES_DEF,
    parameter int CQ_ENTRY_BYTES   = CQ_ENTRY_BYTES_DEF,
    parameter int MAX_RING_ENTRIES = MAX_RING_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  scrc_cmd_t            cmd,
    output logic                 done,
    output scrc_rsp_t            rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_APPLY = 3'd1;
    localparam logic [2:0] S_DEPTH = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [LIMIT_W-1:0] SIZE_LIMIT = LIMIT_W'(MAX_RING_ENTRIES);
    localparam logic [BYTES_W-1:0] SQ_BYTES   = BYTES_W'(SQ_ENTRY_BYTES);
    localparam logic [BYTES_W-1:0] CQ_BYTES   = BYTES_W'(CQ_ENTRY_BYTES);
    localparam int PROD_W = SIZE_W + BYTES_W;

    logic [2:0]          state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [PTR_W-1:0]    value_reg, value_next;
    logic [ADDR_W-1:0]   sq_base_reg, sq_base_next;
    logic [ADDR_W-1:0]   cq_base_reg, cq_base_next;
    logic [SIZE_W-1:0]   sq_entries_reg, sq_entries_next;
    logic [SIZE_W-1:0]   cq_entries_reg, cq_entries_next;
    logic [PTR_W-1:0]    sq_head_reg, sq_head_next;
    logic [PTR_W-1:0]    sq_tail_reg, sq_tail_next;
    logic [PTR_W-1:0]    cq_head_reg, cq_head_next;
    logic [PTR_W-1:0]    cq_tail_reg, cq_tail_next;
    logic [SIZE_W-1:0]   sq_depth_reg, sq_depth_next;
    logic [SIZE_W-1:0]   cq_depth_reg, cq_depth_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                cfg_fire;
    logic [SIZE_W-1:0]   size_clamped;
    logic                sq_ready;
    logic                cq_ready;
    logic                pick_sq;
    logic                room;
    scrc_div_req_t       div_req;
    scrc_div_rsp_t       div_rsp;

    function automatic logic [SIZE_W-1:0] ring_depth(
        input logic [PTR_W-1:0]  head,
        input logic [PTR_W-1:0]  tail,
        input logic [SIZE_W-1:0] size
    );
        logic [PTR_W-1:0] diff;
        begin
            diff = tail - head;
            if (size == '0 || tail < head)
                ring_depth = '0;
            else if (diff < PTR_W'(size))
                ring_depth = diff[SIZE_W-1:0];
            else
                ring_depth = size;
        end
    endfunction

    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = state_reg == S_IDLE;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign done      = state_reg == S_DONE;

    assign size_clamped = ({{(LIMIT_W-SIZE_W){1'b0}}, cfg_data[SIZE_W-1:0]} <= SIZE_LIMIT)
                          ? cfg_data[SIZE_W-1:0] : '0;

    assign sq_ready = sq_base_reg != '0 && sq_entries_reg != '0;
    assign cq_ready = cq_base_reg != '0 && cq_entries_reg != '0;
    assign room     = cq_ready && cq_depth_reg < cq_entries_reg;
    assign pick_sq  = kind_reg == KIND_NEXT_SQ;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        sq_base_next    = sq_base_reg;
        cq_base_next    = cq_base_reg;
        sq_entries_next = sq_entries_reg;
        cq_entries_next = cq_entries_reg;
        sq_head_next    = sq_head_reg;
        sq_tail_next    = sq_tail_reg;
        cq_head_next    = cq_head_reg;
        cq_tail_next    = cq_tail_reg;
        sq_depth_next   = sq_depth_reg;
        cq_depth_next   = cq_depth_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        prod_next       = prod_reg;
        div_req.start    = 1'b0;
        div_req.dividend = pick_sq ? sq_head_reg : cq_tail_reg;
        div_req.divisor  = pick_sq ? sq_entries_reg : cq_entries_reg;

        if (cfg_fire)
        begin
            case (cfg_index)
                REG_SQ_BASE:    sq_base_next = cfg_data;
                REG_CQ_BASE:    cq_base_next = cfg_data;
                REG_SQ_ENTRIES:
                begin
                    sq_entries_next = size_clamped;
                    sq_head_next    = '0;
                    sq_tail_next    = '0;
                end
                REG_CQ_ENTRIES:
                begin
                    cq_entries_next = size_clamped;
                    cq_head_next    = '0;
                    cq_tail_next    = '0;
                end
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = cmd.kind;
                    value_next = cmd.value;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                status_next = STATUS_OK;
                addr_next   = '0;
                case (kind_reg)
                    KIND_SET_SQ_HEAD: sq_head_next = value_reg;
                    KIND_SET_SQ_TAIL: sq_tail_next = value_reg;
                    KIND_SET_CQ_HEAD: cq_head_next = value_reg;
                    KIND_SET_CQ_TAIL: cq_tail_next = value_reg;
                    KIND_ADV_SQ_HEAD: sq_head_next = sq_head_reg + 1'b1;
                    KIND_ADV_CQ_TAIL: cq_tail_next = cq_tail_reg + 1'b1;
                    default: ;
                endcase
                state_next = S_DEPTH;
            end
            S_DEPTH:
            begin
                sq_depth_next = ring_depth(sq_head_reg, sq_tail_reg, sq_entries_reg);
                cq_depth_next = ring_depth(cq_head_reg, cq_tail_reg, cq_entries_reg);
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_DONE;
                if (kind_reg == KIND_NEXT_SQ)
                begin
                    if (!sq_ready || sq_depth_reg == '0)
                        status_next = STATUS_SQ_FAIL;
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else if (kind_reg == KIND_NEXT_CQ)
                begin
                    if (!room)
                        status_next = STATUS_CQ_FAIL;
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    prod_next  = {{BYTES_W{1'b0}}, div_rsp.remainder}
                                 * {{SIZE_W{1'b0}}, (pick_sq ? SQ_BYTES : CQ_BYTES)};
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                addr_next  = (pick_sq ? sq_base_reg : cq_base_reg)
                             + {{(ADDR_W-PROD_W){1'b0}}, prod_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sq_base_reg    <= '0;
            cq_base_reg    <= '0;
            sq_entries_reg <= '0;
            cq_entries_reg <= '0;
            sq_head_reg    <= '0;
            sq_tail_reg    <= '0;
            cq_head_reg    <= '0;
            cq_tail_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sq_base_reg    <= sq_base_next;
            cq_base_reg    <= cq_base_next;
            sq_entries_reg <= sq_entries_next;
            cq_entries_reg <= cq_entries_next;
            sq_head_reg    <= sq_head_next;
            sq_tail_reg    <= sq_tail_next;
            cq_head_reg    <= cq_head_next;
            cq_tail_reg    <= cq_tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        value_reg    <= value_next;
        sq_depth_reg <= sq_depth_next;
        cq_depth_reg <= cq_depth_next;
        status_reg   <= status_next;
        addr_reg     <= addr_next;
        prod_reg     <= prod_next;
    end

    scrc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rsp.status      = status_reg;
    assign rsp.record_addr = addr_reg;
    assign rsp.sq_pending  = sq_depth_reg;
    assign rsp.cq_filled   = cq_depth_reg;
    assign rsp.cq_room     = room;
    assign rsp.sq_ready    = sq_ready;
    assign rsp.cq_ready    = cq_ready;
    assign rsp.sq_head_now = sq_head_reg;
    assign rsp.sq_tail_now = sq_tail_reg;
    assign rsp.cq_head_now = cq_head_reg;
    assign rsp.cq_tail_now = cq_tail_reg;

    `SCRC_ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe not a single cycle")
    `SCRC_ASSERT_NOW(a_fail_no_addr, done && status_reg != STATUS_OK, addr_reg == '0, "refused addr")
    `SCRC_ASSERT_NOW(a_room_depth, done && room, cq_depth_reg < cq_entries_reg, "room on full ring")
    `SCRC_ASSERT_NOW(a_div_only_wait, div_rsp.done, state_reg == S_DIV, "remainder outside wait")

endmodule

### bench/submission_completion_ring_checker.sv
// Ring control checker: tracks pointers and registers, predicts each result and compares it.
module submission_completion_ring_checker
    import scrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  scrc_cmd_t            cmd,
    input  logic                 done,
    input  scrc_rsp_t            rsp,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 flush,
    output int                   outstanding,
    output int                   fails
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 100;

    logic [ADDR_W-1:0] sq_base;
    logic [ADDR_W-1:0] cq_base;
    logic [SIZE_W-1:0] sq_size;
    logic [SIZE_W-1:0] cq_size;
    logic [PTR_W-1:0]  sq_head;
    logic [PTR_W-1:0]  sq_tail;
    logic [PTR_W-1:0]  cq_head;
    logic [PTR_W-1:0]  cq_tail;

    scrc_rsp_t pending_results[$];

    task automatic report_mismatch(input string what);
        if (fails < PRINT_CAP)
            $display("MISMATCH at %0t: %s", $time, what);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // depth is zero when the size is zero or tail trails head, otherwise capped at the ring size
    function automatic logic [SIZE_W-1:0] fill_level(input logic [PTR_W-1:0] head,
                                                     input logic [PTR_W-1:0] tail,
                                                     input logic [SIZE_W-1:0] size);
        logic [PTR_W-1:0] d;
        if (size == '0 || tail < head)
            return '0;
        d = tail - head;
        return (d < PTR_W'(size)) ? d[SIZE_W-1:0] : size;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_address(input logic [ADDR_W-1:0] base,
                                                       input logic [PTR_W-1:0] ptr,
                                                       input logic [SIZE_W-1:0] size,
                                                       input int unsigned bytes);
        logic [PTR_W-1:0] idx;
        idx = ptr % PTR_W'(size);
        return base + ADDR_W'(idx) * ADDR_W'(bytes);
    endfunction

    function automatic logic sq_on();
        return sq_base != '0 && sq_size != '0;
    endfunction

    function automatic logic cq_on();
        return cq_base != '0 && cq_size != '0;
    endfunction

    // only the low 13 bits are kept; anything above the maximum means no ring
    function automatic logic [SIZE_W-1:0] legal_size(input logic [ADDR_W-1:0] data);
        logic [SIZE_W-1:0] v;
        v = data[SIZE_W-1:0];
        return (int'(v) <= MAX_RING_ENTRIES_DEF) ? v : '0;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] data);
        case (idx)
            REG_SQ_BASE: sq_base = data;
            REG_CQ_BASE: cq_base = data;
            REG_SQ_ENTRIES:
            begin
                sq_size = legal_size(data);
                sq_head = '0;
                sq_tail = '0;
            end
            REG_CQ_ENTRIES:
            begin
                cq_size = legal_size(data);
                cq_head = '0;
                cq_tail = '0;
            end
            default: ;
        endcase
    endtask

    function automatic scrc_rsp_t step_rings(input scrc_cmd_t c);
        scrc_rsp_t r;
        r = '0;
        r.status = STATUS_OK;
        case (c.kind)
            KIND_SET_SQ_HEAD: sq_head = c.value;
            KIND_SET_SQ_TAIL: sq_tail = c.value;
            KIND_SET_CQ_HEAD: cq_head = c.value;
            KIND_SET_CQ_TAIL: cq_tail = c.value;
            KIND_NEXT_SQ:
            begin
                if (!sq_on() || fill_level(sq_head, sq_tail, sq_size) == '0)
                    r.status = STATUS_SQ_FAIL;
                else
                    r.record_addr = slot_address(sq_base, sq_head, sq_size,
                                                 SQ_ENTRY_BYTES_DEF);
            end
            KIND_ADV_SQ_HEAD: sq_head = sq_head + 1'b1;
            KIND_NEXT_CQ:
            begin
                if (!cq_on() || fill_level(cq_head, cq_tail, cq_size) >= cq_size)
                    r.status = STATUS_CQ_FAIL;
                else
                    r.record_addr = slot_address(cq_base, cq_tail, cq_size,
                                                 CQ_ENTRY_BYTES_DEF);
            end
            KIND_ADV_CQ_TAIL: cq_tail = cq_tail + 1'b1;
            default: ;
        endcase
        r.sq_pending  = fill_level(sq_head, sq_tail, sq_size);
        r.cq_filled   = fill_level(cq_head, cq_tail, cq_size);
        r.cq_room     = cq_on() && r.cq_filled < cq_size;
        r.sq_ready    = sq_on();
        r.cq_ready    = cq_on();
        r.sq_head_now = sq_head;
        r.sq_tail_now = sq_tail;
        r.cq_head_now = cq_head;
        r.cq_tail_now = cq_tail;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scrc_rsp_t want;
        if (!rst_n)
        begin
            sq_base = '0;
            cq_base = '0;
            sq_size = '0;
            cq_size = '0;
            sq_head = '0;
            sq_tail = '0;
            cq_head = '0;
            cq_tail = '0;
            pending_results.delete();
            fails = 0;
            outstanding <= 0;
        end
        else
        begin
            // a result seen here belongs to an earlier transfer, so pop first
            if (done)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result strobe with nothing expected");
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 64'(rsp.status), 64'(want.status));
                    check_field("record_addr", rsp.record_addr, want.record_addr);
                    check_field("sq_pending", 64'(rsp.sq_pending), 64'(want.sq_pending));
                    check_field("cq_filled", 64'(rsp.cq_filled), 64'(want.cq_filled));
                    check_field("cq_room", 64'(rsp.cq_room), 64'(want.cq_room));
                    check_field("sq_ready", 64'(rsp.sq_ready), 64'(want.sq_ready));
                    check_field("cq_ready", 64'(rsp.cq_ready), 64'(want.cq_ready));
                    check_field("sq_head_now", 64'(rsp.sq_head_now), 64'(want.sq_head_now));
                    check_field("sq_tail_now", 64'(rsp.sq_tail_now), 64'(want.sq_tail_now));
                    check_field("cq_head_now", 64'(rsp.cq_head_now), 64'(want.cq_head_now));
                    check_field("cq_tail_now", 64'(rsp.cq_tail_now), 64'(want.cq_tail_now));
                end
            end
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (start && !busy)
                pending_results.push_back(step_rings(cmd));
            if (flush && pending_results.size() != 0)
            begin
                report_mismatch($sformatf("%0d expected results never arrived",
                                          pending_results.size()));
                pending_results.delete();
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

### bench/tb_submission_completion_ring_control.sv
// Testbench top for the ring control: clock, reset, command and register traffic, verdict.
module tb_submission_completion_ring_control import scrc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400_000;
    localparam int SETTING_ITEMS = 55;
    localparam int DRAIN_CYCLES = 50;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    scrc_cmd_t            cmd;
    logic                 done;
    scrc_rsp_t            rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 flush;
    int                   outstanding;
    int                   fails;

    int                   idle_pct;
    int                   items_sent;
    int                   reg_writes;
    logic [PTR_W-1:0]     anchor;

    submission_completion_ring_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    submission_completion_ring_checker ring_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .flush       (flush),
        .outstanding (outstanding),
        .fails       (fails)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still due", LIMIT_CYCLES,
                 outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    // all drive tasks are entered and left just after a falling edge
    task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [PTR_W-1:0] v);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start = 1'b1;
        cmd = '{kind: k, value: v};
        do @(posedge clk); while (busy);
        @(negedge clk);
        items_sent++;
    endtask

    // drop start and wait until every result is back and the block is free
    task automatic quiesce();
        start = 1'b0;
        while (outstanding != 0 || busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        reg_writes++;
    endtask

    task automatic set_rings(input logic [ADDR_W-1:0] sqb, input logic [ADDR_W-1:0] cqb,
                             input logic [ADDR_W-1:0] sqn, input logic [ADDR_W-1:0] cqn);
        quiesce();
        write_reg(REG_SQ_BASE, sqb);
        write_reg(REG_CQ_BASE, cqb);
        write_reg(REG_SQ_ENTRIES, sqn);
        write_reg(REG_CQ_ENTRIES, cqn);
    endtask

    function automatic logic [ADDR_W-1:0] rand_base();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 64'hFFFF_FFFF_FFFF_F000 | ADDR_W'($urandom_range(0, 4095));
            2, 3: return {$urandom, $urandom};
            default: return ADDR_W'($urandom) << 12;
        endcase
    endfunction

    // small rings mostly so that full and empty come up often
    function automatic logic [ADDR_W-1:0] rand_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return ADDR_W'($urandom_range(1, 8));
            6: return ADDR_W'(MAX_RING_ENTRIES_DEF);
            7: return '0;
            8: return ADDR_W'($urandom_range(MAX_RING_ENTRIES_DEF + 1, 8191));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [PTR_W-1:0] pick_ptr();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return anchor + PTR_W'($urandom_range(0, 24));
            5, 6: return anchor - PTR_W'($urandom_range(0, 8));
            7: return $urandom;
            8: return 32'hFFFF_FFFF - PTR_W'($urandom_range(0, 8));
            default: return PTR_W'($urandom_range(0, 8));
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] rand_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return KIND_SET_SQ_HEAD;
        if (r < 20) return KIND_SET_SQ_TAIL;
        if (r < 30) return KIND_SET_CQ_HEAD;
        if (r < 40) return KIND_SET_CQ_TAIL;
        if (r < 55) return KIND_NEXT_SQ;
        if (r < 70) return KIND_ADV_SQ_HEAD;
        if (r < 85) return KIND_NEXT_CQ;
        return KIND_ADV_CQ_TAIL;
    endfunction

    initial
    begin
        int target;
        int idle_by_phase[4];
        idle_by_phase = '{0, 49, 0, 12};
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        flush = 1'b0;
        idle_pct = 0;
        items_sent = 0;
        reg_writes = 0;
        anchor = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // nothing configured: both address requests are refused
        send_cmd(KIND_NEXT_SQ, 32'hFFFF_FFFF);
        send_cmd(KIND_NEXT_CQ, 32'h0);
        send_cmd(KIND_ADV_CQ_TAIL, 32'h0);

        // largest rings, bases at the top so record addresses wrap past 2^64
        set_rings(64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF,
                  ADDR_W'(MAX_RING_ENTRIES_DEF), ADDR_W'(MAX_RING_ENTRIES_DEF));
        send_cmd(KIND_SET_SQ_HEAD, 32'hFFFF_FFFE);
        send_cmd(KIND_SET_SQ_TAIL, 32'hFFFF_FFFF);
        send_cmd(KIND_NEXT_SQ, 32'h0);
        send_cmd(KIND_ADV_SQ_HEAD, 32'h0);
        send_cmd(KIND_NEXT_SQ, 32'h0);
        send_cmd(KIND_ADV_SQ_HEAD, 32'hFFFF_FFFF);
        send_cmd(KIND_NEXT_SQ, 32'h0);
        send_cmd(KIND_SET_SQ_HEAD, 32'hAAAA_AAAA);
        send_cmd(KIND_SET_SQ_TAIL, 32'h5555_5555);
        send_cmd(KIND_SET_CQ_TAIL, 32'd4096);
        send_cmd(KIND_NEXT_CQ, 32'h0);
        send_cmd(KIND_SET_CQ_HEAD, 32'd1);
        send_cmd(KIND_NEXT_CQ, 32'h0);
        send_cmd(KIND_ADV_CQ_TAIL, 32'h0);
        send_cmd(KIND_SET_CQ_TAIL, 32'hFFFF_FFFF);
        send_cmd(KIND_ADV_CQ_TAIL, 32'h0);

        // oversized write stores zero; junk above bit 12 is dropped leaving size 1
        set_rings(64'h0, 64'h0000_0000_0000_1000,
                  ADDR_W'(MAX_RING_ENTRIES_DEF + 1), 64'hFFFF_FFFF_FFFF_E001);
        send_cmd(KIND_SET_SQ_TAIL, 32'd3);
        send_cmd(KIND_NEXT_SQ, 32'h0);
        send_cmd(KIND_NEXT_CQ, 32'h0);
        send_cmd(KIND_ADV_CQ_TAIL, 32'h0);
        send_cmd(KIND_NEXT_CQ, 32'h0);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_by_phase[ph];
            repeat (4)
            begin
                set_rings(rand_base(), rand_base(), rand_size(), rand_size());
                case ($urandom_range(0, 2))
                    0: anchor = '0;
                    1: anchor = 32'hFFFF_FFFF - PTR_W'($urandom_range(0, 30));
                    default: anchor = $urandom;
                endcase
                target = items_sent + SETTING_ITEMS;
                while (items_sent < target)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            // consumer pass: fetch a record, then retire it
                            repeat ($urandom_range(1, 4))
                            begin
                                send_cmd(KIND_NEXT_SQ, $urandom);
                                send_cmd(KIND_ADV_SQ_HEAD, $urandom);
                            end
                        end
                        1:
                        begin
                            // producer pass: claim a slot, then post it
                            repeat ($urandom_range(1, 4))
                            begin
                                send_cmd(KIND_NEXT_CQ, $urandom);
                                send_cmd(KIND_ADV_CQ_TAIL, $urandom);
                            end
                        end
                        default: send_cmd(rand_kind(), pick_ptr());
                    endcase
                end
            end
        end

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        flush = 1'b1;
        @(negedge clk);
        flush = 1'b0;
        @(negedge clk);

        $display("Ran %0d commands of all eight kinds with %0d register writes,", items_sent,
                 reg_writes);
        $display("covering pointer wrap, full and empty rings, bad sizes and four idle mixes.");
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/scrc_pkg.sv
rtl/core/scrc_divider.sv
rtl/core/submission_completion_ring_control.sv
bench/submission_completion_ring_checker.sv
bench/tb_submission_completion_ring_control.sv
